// File: sv/rtcm3fc_pkg.sv
// shared types, constants and the crc-24q byte update for the rtcm3 frame checker
package rtcm3fc_pkg;

  localparam int unsigned MaxFrameBytes = 1029;
  localparam int unsigned CountW        = 11;
  localparam logic [CountW-1:0] CountSat = CountW'(MaxFrameBytes + 1);
  localparam logic [CountW-1:0] CountMax = CountW'(MaxFrameBytes);
  localparam logic [CountW-1:0] MinFrame = CountW'(8);

  localparam logic [23:0] CrcPoly      = 24'h864CFB;
  localparam logic [7:0]  Preamble     = 8'hD3;
  localparam logic [7:0]  ReservedMask = 8'hFC;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_SHORT    = 3'd1;
  localparam logic [2:0] STATUS_LONG     = 3'd2;
  localparam logic [2:0] STATUS_PREAMBLE = 3'd3;
  localparam logic [2:0] STATUS_RESERVED = 3'd4;
  localparam logic [2:0] STATUS_LEN      = 3'd5;
  localparam logic [2:0] STATUS_CRC      = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              frame_ok;
    logic [2:0]        status;
    logic [11:0]       type_code;
    logic [CountW-1:0] byte_total;
  } out_item_t;

  // one byte through crc-24q, msb first, unrolled over the eight bits
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc, input logic [7:0] b);
    logic [23:0] c;
    logic        top;
    c = crc ^ {b, 16'h0000};
    for (int i = 0; i < 8; i++) begin
      top = c[23];
      c   = {c[22:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/rtcm3fc_tracker.sv
// per-frame state: byte count, header capture, delayed crc and the final verdict
module rtcm3fc_tracker
  import rtcm3fc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  output out_item_t verdict_o
);

  logic [CountW-1:0] count_q, count_d;
  logic [23:0]       crc_q, crc_d;
  logic [23:0]       window_q, window_d;
  logic [1:0]        hdr_q, hdr_d;
  logic [9:0]        plen_q, plen_d;
  logic [11:0]       mtype_q, mtype_d;
  logic [2:0]        status;
  logic [CountW-1:0] plen_plus;

  always_comb begin
    hdr_d   = hdr_q;
    plen_d  = plen_q;
    mtype_d = mtype_q;
    case (count_q)
      CountW'(0): if (item_i.data_byte == Preamble) hdr_d[0] = 1'b1;
      CountW'(1): begin
        if ((item_i.data_byte & ReservedMask) == 8'h00) hdr_d[1] = 1'b1;
        plen_d[9:8] = item_i.data_byte[1:0];
      end
      CountW'(2): plen_d[7:0] = item_i.data_byte;
      CountW'(3): mtype_d[11:4] = item_i.data_byte;
      CountW'(4): mtype_d[3:0] = item_i.data_byte[7:4];
      default: ;
    endcase

    // bytes reach the crc only after three bytes of delay
    crc_d    = (count_q >= CountW'(3)) ? crc24q_byte(crc_q, window_q[23:16]) : crc_q;
    window_d = {window_q[15:0], item_i.data_byte};
    count_d  = (count_q < CountSat) ? count_q + CountW'(1) : count_q;

    plen_plus = CountW'(plen_d) + CountW'(6);
    if (count_d < MinFrame)        status = STATUS_SHORT;
    else if (count_d > CountMax)   status = STATUS_LONG;
    else if (!hdr_d[0])            status = STATUS_PREAMBLE;
    else if (!hdr_d[1])            status = STATUS_RESERVED;
    else if (count_d != plen_plus) status = STATUS_LEN;
    else if (window_d != crc_d)    status = STATUS_CRC;
    else                           status = STATUS_OK;

    verdict_o.frame_ok   = (status == STATUS_OK);
    verdict_o.status     = status;
    verdict_o.type_code  = (count_d < MinFrame) ? 12'h000 : mtype_d;
    verdict_o.byte_total = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      crc_q    <= '0;
      window_q <= '0;
      hdr_q    <= '0;
      plen_q   <= '0;
      mtype_q  <= '0;
    end else if (step_i) begin
      if (item_i.last_byte) begin
        count_q  <= '0;
        crc_q    <= '0;
        window_q <= '0;
        hdr_q    <= '0;
        plen_q   <= '0;
        mtype_q  <= '0;
      end else begin
        count_q  <= count_d;
        crc_q    <= crc_d;
        window_q <= window_d;
        hdr_q    <= hdr_d;
        plen_q   <= plen_d;
        mtype_q  <= mtype_d;
      end
    end
  end

endmodule

// File: sv/rtcm3_frame_checker_core.sv
// top level of the rtcm3 frame checker: input register, frame tracker, result register
//
// channel  dir  handshake              payload
// in       in   in_valid_i/in_stall_o  in_item_i   (one frame byte, last flag)
// out      out  out_valid_o/out_stall_i out_item_o (verdict of one frame)
//
// one byte per clock unless a last byte is held back; a byte goes from the
// input register through the crc and header logic into the tracker state, and
// the verdict of a frame is registered in the result register as its last byte
// leaves the input register. all control state clears on reset. a waiting
// verdict only holds back the input when the byte in the input register is itself a last byte.
module rtcm3_frame_checker_core
  import rtcm3fc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t verdict;
  logic      step;
  logic      in_take;

  // a non-final item never needs the result register
  assign step    = in_valid_q && (!in_item_q.last_byte || !out_valid_q || !out_stall_i);
  assign in_take = in_valid_i && !in_stall_o;
  assign in_stall_o = in_valid_q && !step;

  rtcm3fc_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .item_i    (in_item_q),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step && in_item_q.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q <= in_item_i;
    end
    if (step && in_item_q.last_byte) begin
      out_item_q <= verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: test/rtcm3_verdict_checker.sv
`timescale 1ns / 1ps
// scoreboard for the rtcm3 frame checker: predicts each frame verdict and compares it
module rtcm3_verdict_checker
  import rtcm3fc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_item_i,
  output int unsigned mismatch_count_o,
  output int unsigned verdicts_pending_o
);

  // frame state of the predictor
  logic [10:0] frame_count;
  logic [23:0] crc_acc;
  logic [23:0] tail_bytes;
  logic        preamble_seen;
  logic        reserved_clear;
  logic [9:0]  payload_len;
  logic [11:0] msg_type;

  out_item_t   verdict_q[$];
  int unsigned mismatches;

  function automatic logic [23:0] crc24q_step(logic [23:0] acc, logic [7:0] b);
    logic [24:0] r;
    r = {1'b0, acc ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      r = r << 1;
      if (r[24]) begin
        r = r ^ 25'h1864CFB;
      end
    end
    return r[23:0];
  endfunction

  task automatic clear_frame();
    frame_count    = '0;
    crc_acc        = '0;
    tail_bytes     = '0;
    preamble_seen  = 1'b0;
    reserved_clear = 1'b0;
    payload_len    = '0;
    msg_type       = '0;
  endtask

  task automatic absorb_byte(in_item_t it);
    logic [7:0] b;
    logic [2:0] st;
    out_item_t  v;
    b = it.data_byte;
    case (frame_count)
      11'd0: begin
        if (b == Preamble) preamble_seen = 1'b1;
      end
      11'd1: begin
        if ((b & ReservedMask) == 8'h00) reserved_clear = 1'b1;
        payload_len[9:8] = b[1:0];
      end
      11'd2: payload_len[7:0] = b;
      11'd3: msg_type[11:4] = b;
      11'd4: msg_type[3:0] = b[7:4];
      default: ;
    endcase
    // the crc sees a byte once it drops out of the three-byte tail
    if (frame_count >= 11'd3) crc_acc = crc24q_step(crc_acc, tail_bytes[23:16]);
    tail_bytes = {tail_bytes[15:0], b};
    if (frame_count < CountSat) frame_count = frame_count + 11'd1;
    if (it.last_byte) begin
      if (frame_count < MinFrame) st = STATUS_SHORT;
      else if (frame_count > CountMax) st = STATUS_LONG;
      else if (!preamble_seen) st = STATUS_PREAMBLE;
      else if (!reserved_clear) st = STATUS_RESERVED;
      else if (frame_count != {1'b0, payload_len} + 11'd6) st = STATUS_LEN;
      else if (tail_bytes != crc_acc) st = STATUS_CRC;
      else st = STATUS_OK;
      v.frame_ok   = (st == STATUS_OK);
      v.status     = st;
      v.type_code  = (frame_count < MinFrame) ? 12'h000 : msg_type;
      v.byte_total = frame_count;
      verdict_q.push_back(v);
      clear_frame();
    end
  endtask

  task automatic compare_verdict(out_item_t got);
    out_item_t want;
    if (verdict_q.size() == 0) begin
      $error("unexpected verdict: status actual %0d, byte_total actual %0d",
             got.status, got.byte_total);
      mismatches++;
    end else begin
      want = verdict_q.pop_front();
      if (got.frame_ok !== want.frame_ok) begin
        $error("frame_ok expected %0d actual %0d", want.frame_ok, got.frame_ok);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.type_code !== want.type_code) begin
        $error("type_code expected %0d actual %0d", want.type_code, got.type_code);
        mismatches++;
      end
      if (got.byte_total !== want.byte_total) begin
        $error("byte_total expected %0d actual %0d", want.byte_total, got.byte_total);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      verdict_q.delete();
      mismatches = 0;
      mismatch_count_o   <= 0;
      verdicts_pending_o <= 0;
    end else begin
      // output side first so a stray verdict is never masked by a new frame end
      if (out_valid_i && !out_stall_i) compare_verdict(out_item_i);
      if (in_valid_i && !in_stall_i) absorb_byte(in_item_i);
      mismatch_count_o   <= mismatches;
      verdicts_pending_o <= verdict_q.size();
    end
  end

endmodule

// File: test/tb_rtcm3_frame_checker_core.sv
`timescale 1ns / 1ps
// testbench top for the rtcm3 frame checker: clock, reset, frame stimulus and verdict
module tb_rtcm3_frame_checker_core;
  import rtcm3fc_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned RandomItems   = 250;
  localparam int unsigned QuietItems    = 100;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  int unsigned mismatch_count;
  int unsigned verdicts_pending;
  int unsigned items_sent   = 0;
  int unsigned stuck_cycles = 0;
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;
  logic [7:0]  frame_bytes[$];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rtcm3_frame_checker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  rtcm3_verdict_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .in_item_i         (in_item_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_item_i        (out_item_o),
    .mismatch_count_o  (mismatch_count),
    .verdicts_pending_o(verdicts_pending)
  );

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: one long hold-off when asked, random stall bursts otherwise while idle_on is set
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [23:0] frame_crc();
    logic [24:0] r;
    r = '0;
    foreach (frame_bytes[i]) begin
      r[23:16] = r[23:16] ^ frame_bytes[i];
      for (int k = 0; k < 8; k++) begin
        r = r << 1;
        if (r[24]) r = r ^ 25'h1864CFB;
      end
    end
    return r[23:0];
  endfunction

  // well-formed frame: header, payload led by the type, crc-24q trailer
  task automatic build_frame(logic [9:0] plen, logic [11:0] mtype);
    logic [23:0] crc;
    frame_bytes.delete();
    frame_bytes.push_back(Preamble);
    frame_bytes.push_back({6'b000000, plen[9:8]});
    frame_bytes.push_back(plen[7:0]);
    for (int i = 0; i < plen; i++) begin
      if (i == 0) frame_bytes.push_back(mtype[11:4]);
      else if (i == 1) frame_bytes.push_back({mtype[3:0], 4'($urandom)});
      else frame_bytes.push_back(8'($urandom));
    end
    crc = frame_crc();
    frame_bytes.push_back(crc[23:16]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) begin
      if (idle_on && $urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_item_i  <= '{data_byte: frame_bytes[i], last_byte: (i == frame_bytes.size() - 1)};
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      items_sent++;
    end
  endtask

  task automatic send_random_frame();
    int unsigned kind;
    int unsigned idx;
    kind = $urandom_range(0, 11);
    if (kind <= 9) build_frame(10'($urandom_range(2, 24)), 12'($urandom));
    case (kind)
      5: frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
      6: frame_bytes[1] = frame_bytes[1] | {6'($urandom_range(1, 63)), 2'b00};
      7: frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
      8: begin
        idx = $urandom_range(3, frame_bytes.size() - 1);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      10: begin
        frame_bytes.delete();
        repeat ($urandom_range(1, 7)) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) frame_bytes[0] = Preamble;
      end
      11: begin
        frame_bytes.delete();
        repeat ($urandom_range(8, 40)) frame_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_frame();
  endtask

  initial begin
    int unsigned stop_at;
    rst_ni = 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single byte frame, smallest good frame, seven byte frame, bad preamble
    frame_bytes = '{Preamble};
    send_frame();
    build_frame(10'd2, 12'hFFF);
    send_frame();
    build_frame(10'd1, 12'hABC);
    send_frame();
    build_frame(10'd2, 12'h000);
    frame_bytes[0] = 8'h00;
    send_frame();

    // receiver holds off while one-byte frames keep arriving
    hold_req = 1'b1;
    repeat (30) begin
      frame_bytes = '{8'($urandom)};
      send_frame();
    end

    // frame two bytes past the maximum, so the count saturates
    build_frame(10'd1023, 12'($urandom));
    repeat (2) frame_bytes.push_back(8'($urandom));
    send_frame();

    stop_at = items_sent + RandomItems;
    while (items_sent < stop_at) send_random_frame();
    idle_on = 1'b0;
    stop_at = items_sent + QuietItems;
    while (items_sent < stop_at) send_random_frame();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (verdicts_pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/rtcm3fc_pkg.sv
sv/rtcm3fc_tracker.sv
sv/rtcm3_frame_checker_core.sv
test/rtcm3_verdict_checker.sv
test/tb_rtcm3_frame_checker_core.sv
